[hdl/eaa_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// eaa_pkg: shared types and constants of the encoder angle averager
// Field widths, opcode and code limits, and the control word of the shared ALU.
// ----------------------------------------------------------------------------
package eaa_pkg;

   localparam int CODE_W = 12;
   localparam int WORD_W = 16;
   localparam int FINE_W = 21;
   localparam int MUL_W  = 9;

   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_TICK   = 1'b1;

   localparam logic [CODE_W-1:0] CODE_MIN_REJ = 12'h000;
   localparam logic [CODE_W-1:0] CODE_MAX_REJ = 12'hFFF;
   localparam logic [MUL_W-1:0]  DEG_PER_TURN = 9'd360;

   typedef enum logic {
      ALU_ADD,
      ALU_SUB
   } alu_op_type;

   typedef struct packed {
      alu_op_type op;
      logic       force_zero_b;
   } alu_ctl_type;

endpackage
`default_nettype wire

[hdl/eaa_req_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// eaa_req_if: request channel
// Valid/ready channel carrying one opcode and one raw encoder word per word.
// ----------------------------------------------------------------------------
interface eaa_req_if;
   logic                       valid;
   logic                       ready;
   logic                       opcode;
   logic [eaa_pkg::WORD_W-1:0] raw_word;

   modport source (output valid, output opcode, output raw_word, input ready);
   modport sink   (input valid, input opcode, input raw_word, output ready);
endinterface
`default_nettype wire

[hdl/eaa_rsp_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// eaa_rsp_if: response channel
// Valid/ready channel carrying the averaged angle code and fine angle.
// ----------------------------------------------------------------------------
interface eaa_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [eaa_pkg::CODE_W-1:0] angle_code;
   logic [eaa_pkg::FINE_W-1:0] angle_fine;

   modport source (output valid, output angle_code, output angle_fine, input ready);
   modport sink   (input valid, input angle_code, input angle_fine, output ready);
endinterface
`default_nettype wire

[hdl/eaa_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// eaa_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module eaa_ram #(
   parameter int WIDTH = 12,
   parameter int DEPTH = 8
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

[hdl/eaa_alu.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// eaa_alu: shared add/subtract unit
// Used for ring accumulation and offset removal.
// ----------------------------------------------------------------------------
module eaa_alu #(
   parameter int W = 15
) (
   input  wire eaa_pkg::alu_ctl_type ctl,
   input  wire logic [W-1:0]         a,
   input  wire logic [W-1:0]         b,
   output logic      [W-1:0]         y
);

   logic [W-1:0] b_eff;
   logic         sub;

   always_comb begin
      sub   = (ctl.op == eaa_pkg::ALU_SUB);
      b_eff = ctl.force_zero_b ? '0 : b;
      y     = a + (sub ? ~b_eff : b_eff) + W'(sub);
   end

endmodule
`default_nettype wire

[hdl/encoder_angle_averager_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// encoder_angle_averager_top: moving average of absolute encoder codes
// Sample words fill a ring; a tick averages the ring and reports the angle.
// ----------------------------------------------------------------------------
// Sample word: ready again the next cycle.
// Tick word: RING_DEPTH ring reads through one adder, then the drain, divide,
//   offset and multiply states in that order; the result is registered at the
//   output, and the next word is taken once the block is back in idle.
// Not ready while a tick is in flight; the output register holds a result.
// Synchronous reset clears ring valid bits, write slot, offset and control.
// ----------------------------------------------------------------------------
module encoder_angle_averager_top #(
   parameter int RING_DEPTH = 8
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       csr_wr_en,
   input  wire logic [eaa_pkg::CODE_W-1:0] csr_wr_data,
   eaa_req_if.sink                         req,
   eaa_rsp_if.source                       rsp
);

   localparam int AW      = $clog2(RING_DEPTH);
   localparam int SUM_W   = eaa_pkg::CODE_W + AW;
   localparam int DIV_SH  = SUM_W + AW;
   localparam int RECIP_W = SUM_W + 2;
   localparam int PROD_W  = SUM_W + RECIP_W;
   localparam logic [AW-1:0]      LAST_IDX = AW'(RING_DEPTH - 1);
   localparam logic [RECIP_W-1:0] RECIP    =
      RECIP_W'(((1 << DIV_SH) + RING_DEPTH - 1) / RING_DEPTH);

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_DRAIN,
      S_DIV,
      S_OFS,
      S_MUL
   } state_type;

   state_type                  state_ff, state_in;
   logic [RING_DEPTH-1:0]      vld_ff, vld_in;
   logic [AW-1:0]              slot_ff, slot_in;
   logic [AW-1:0]              idx_ff, idx_in;
   logic                       pend_ff, pend_in;
   logic                       vld_rd_ff, vld_rd_in;
   logic [SUM_W-1:0]           acc_ff, acc_in;
   logic [SUM_W-1:0]           quo_ff, quo_in;
   logic [eaa_pkg::CODE_W-1:0] code_ff, code_in;
   logic [eaa_pkg::CODE_W-1:0] offset_ff, offset_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [eaa_pkg::CODE_W-1:0] angle_code_ff, angle_code_in;
   logic [eaa_pkg::FINE_W-1:0] angle_fine_ff, angle_fine_in;

   logic                       req_acc;
   logic [eaa_pkg::CODE_W-1:0] sample_code;
   logic                       keep;
   logic                       ram_wr_en;
   logic                       ram_rd_en;
   logic [eaa_pkg::CODE_W-1:0] ram_rd_data;
   logic [PROD_W-1:0]          div_prod;
   logic                       out_free;

   eaa_pkg::alu_ctl_type       alu_ctl;
   logic [SUM_W-1:0]           alu_a, alu_b, alu_y;

   eaa_ram #(
      .WIDTH (eaa_pkg::CODE_W),
      .DEPTH (RING_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (slot_in),
      .wr_data (sample_code),
      .rd_en   (ram_rd_en),
      .rd_addr (idx_ff),
      .rd_data (ram_rd_data)
   );

   eaa_alu #(
      .W (SUM_W)
   ) u_alu (
      .ctl (alu_ctl),
      .a   (alu_a),
      .b   (alu_b),
      .y   (alu_y)
   );

   assign req.ready  = (state_ff == S_IDLE);
   assign req_acc    = req.valid & req.ready;
   assign sample_code = req.raw_word[eaa_pkg::CODE_W:1];
   assign keep       = (sample_code != eaa_pkg::CODE_MIN_REJ) &&
                       (sample_code != eaa_pkg::CODE_MAX_REJ);
   assign ram_rd_en  = (state_ff == S_READ);
   assign out_free   = ~rsp_valid_ff | rsp.ready;

   // floor(sum / RING_DEPTH) by reciprocal multiply, exact over the sum range
   assign div_prod   = {{RECIP_W{1'b0}}, quo_ff} * {{SUM_W{1'b0}}, RECIP};

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.angle_code = angle_code_ff;
   assign rsp.angle_fine = angle_fine_ff;

   // ALU operand select
   always_comb begin
      alu_ctl.op           = eaa_pkg::ALU_ADD;
      alu_ctl.force_zero_b = 1'b0;
      alu_a                = acc_ff;
      alu_b                = SUM_W'(ram_rd_data);
      unique case (state_ff)
         S_READ, S_DRAIN: begin
            alu_ctl.force_zero_b = ~vld_rd_ff;
         end
         S_OFS: begin
            alu_ctl.op = eaa_pkg::ALU_SUB;
            alu_a      = SUM_W'(quo_ff[eaa_pkg::CODE_W-1:0]);
            alu_b      = SUM_W'(offset_ff);
         end
         S_IDLE, S_DIV, S_MUL: begin
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      vld_in        = vld_ff;
      slot_in       = slot_ff;
      idx_in        = idx_ff;
      pend_in       = (state_ff == S_READ);
      vld_rd_in     = vld_ff[idx_ff];
      acc_in        = acc_ff;
      quo_in        = quo_ff;
      code_in       = code_ff;
      offset_in     = csr_wr_en ? csr_wr_data : offset_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp.ready;
      angle_code_in = angle_code_ff;
      angle_fine_in = angle_fine_ff;
      ram_wr_en     = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               if (req.opcode == eaa_pkg::OP_TICK) begin
                  state_in = S_READ;
                  idx_in   = '0;
                  acc_in   = '0;
               end else if (keep) begin
                  slot_in         = (slot_ff == LAST_IDX) ? '0 : slot_ff + 1'b1;
                  ram_wr_en       = 1'b1;
                  vld_in[slot_in] = 1'b1;
               end
            end
         end
         S_READ: begin
            if (pend_ff) begin
               acc_in = alu_y;
            end
            idx_in = idx_ff + 1'b1;
            if (idx_ff == LAST_IDX) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            quo_in   = alu_y;
            state_in = S_DIV;
         end
         S_DIV: begin
            quo_in   = SUM_W'(div_prod[DIV_SH +: eaa_pkg::CODE_W]);
            state_in = S_OFS;
         end
         S_OFS: begin
            code_in  = alu_y[eaa_pkg::CODE_W-1:0];
            state_in = S_MUL;
         end
         S_MUL: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               angle_code_in = code_ff;
               angle_fine_in = {{(eaa_pkg::FINE_W - eaa_pkg::CODE_W){1'b0}}, code_ff}
                               * eaa_pkg::FINE_W'(eaa_pkg::DEG_PER_TURN);
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         vld_ff       <= '0;
         slot_ff      <= '0;
         idx_ff       <= '0;
         pend_ff      <= 1'b0;
         offset_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         vld_ff       <= vld_in;
         slot_ff      <= slot_in;
         idx_ff       <= idx_in;
         pend_ff      <= pend_in;
         offset_ff    <= offset_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      vld_rd_ff     <= vld_rd_in;
      acc_ff        <= acc_in;
      quo_ff        <= quo_in;
      code_ff       <= code_in;
      angle_code_ff <= angle_code_in;
      angle_fine_ff <= angle_fine_in;
   end

endmodule
`default_nettype wire

[hdl/eaa_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// eaa_checker: port-level checks of the encoder angle averager
// Watches the request and response channels of the top level.
// ----------------------------------------------------------------------------
module eaa_checker (
   input wire logic                       clock,
   input wire logic                       reset,
   input wire logic                       req_valid,
   input wire logic                       req_ready,
   input wire logic                       req_opcode,
   input wire logic                       rsp_valid,
   input wire logic                       rsp_ready,
   input wire logic [eaa_pkg::CODE_W-1:0] rsp_angle_code,
   input wire logic [eaa_pkg::FINE_W-1:0] rsp_angle_fine
);

   logic [eaa_pkg::FINE_W-1:0] fine_exp;

   assign fine_exp = {{(eaa_pkg::FINE_W - eaa_pkg::CODE_W){1'b0}}, rsp_angle_code}
                     * eaa_pkg::FINE_W'(eaa_pkg::DEG_PER_TURN);

   a_fine_matches_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_angle_fine == fine_exp))
      else $error("angle_fine is not angle_code times 360");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_angle_code)))
      else $error("stalled response word changed");

   a_tick_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (req_opcode == eaa_pkg::OP_TICK)) |=> !req_ready)
      else $error("ready stayed high after a tick word");

   a_sample_ready: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (req_opcode == eaa_pkg::OP_SAMPLE)) |=> req_ready)
      else $error("ready dropped after a sample word");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> (!rsp_valid && req_ready))
      else $error("not idle after reset");

endmodule

bind encoder_angle_averager_top eaa_checker u_eaa_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req.valid),
   .req_ready      (req.ready),
   .req_opcode     (req.opcode),
   .rsp_valid      (rsp.valid),
   .rsp_ready      (rsp.ready),
   .rsp_angle_code (rsp.angle_code),
   .rsp_angle_fine (rsp.angle_fine)
);
`default_nettype wire

[sim/tb.sv]
// ----------------------------------------------------------------------------
// tb: testbench for encoder_angle_averager_top
// Drives sample and tick words through the request channel in random bursts
// and stalls the response channel on a rotating pattern. A local tracker of
// the sample ring predicts each averaged angle, and the response monitor
// checks it field by field. The zero offset is rewritten between phases
// while the block is idle.
// ----------------------------------------------------------------------------
module tb;

   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int SETTLE_CYCLES = 40;

   typedef struct packed {
      logic                       op;
      logic [eaa_pkg::WORD_W-1:0] word;
   } req_word_type;

   typedef struct packed {
      logic [eaa_pkg::CODE_W-1:0] code;
      logic [eaa_pkg::FINE_W-1:0] fine;
   } angle_type;

   typedef enum int {
      FILL_ANY,
      FILL_HIGH,
      FILL_LOW
   } fill_mode_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_wr_en;
   logic [eaa_pkg::CODE_W-1:0] csr_wr_data;

   eaa_req_if req_ch();
   eaa_rsp_if rsp_ch();

   encoder_angle_averager_top uut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req         (req_ch.sink),
      .rsp         (rsp_ch.source)
   );

   req_word_type pending_words[$];
   angle_type    expected_angles[$];

   logic [eaa_pkg::CODE_W-1:0] ring_codes[8];
   logic [2:0]                 ring_slot;
   logic [eaa_pkg::CODE_W-1:0] offset_now;

   int error_count = 0;
   int cycle_count = 0;
   int burst_left;
   int gap_left;
   logic [15:0] stall_pattern;
   int pattern_age;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // update the ring tracker with one accepted word; a tick queues the predicted angle
   task automatic track_word(input logic op, input logic [eaa_pkg::WORD_W-1:0] word);
      logic [eaa_pkg::CODE_W-1:0] code;
      logic [eaa_pkg::CODE_W+2:0] sum;
      angle_type want;
      if (op == eaa_pkg::OP_SAMPLE) begin
         code = word[eaa_pkg::CODE_W:1];
         if (code != eaa_pkg::CODE_MIN_REJ && code != eaa_pkg::CODE_MAX_REJ) begin
            ring_slot = ring_slot + 3'd1;
            ring_codes[ring_slot] = code;
         end
      end else begin
         sum = '0;
         for (int k = 0; k < 8; k++) sum = sum + ring_codes[k];
         want.code = sum[eaa_pkg::CODE_W+2:3] - offset_now;
         want.fine = eaa_pkg::FINE_W'(want.code) * eaa_pkg::FINE_W'(eaa_pkg::DEG_PER_TURN);
         expected_angles.push_back(want);
      end
   endtask

   function automatic logic [eaa_pkg::WORD_W-1:0] sample_word(input fill_mode_type mode);
      logic [eaa_pkg::CODE_W-1:0] code;
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) begin
         code = $urandom_range(0, 1) ? eaa_pkg::CODE_MIN_REJ : eaa_pkg::CODE_MAX_REJ;
      end else if (r < 15) begin
         code = $urandom_range(0, 1) ? 12'd1 : 12'd4094;
      end else begin
         case (mode)
            FILL_HIGH: code = eaa_pkg::CODE_W'($urandom_range(3900, 4094));
            FILL_LOW:  code = eaa_pkg::CODE_W'($urandom_range(1, 200));
            default:   code = eaa_pkg::CODE_W'($urandom);
         endcase
      end
      return {3'($urandom), code, 1'($urandom)};
   endfunction

   task automatic queue_random(input int count, input fill_mode_type mode);
      req_word_type item;
      @(negedge clock);
      for (int k = 0; k < count; k++) begin
         if ($urandom_range(0, 99) < 22) begin
            item.op = eaa_pkg::OP_TICK;
            item.word = eaa_pkg::WORD_W'($urandom);
         end else begin
            item.op = eaa_pkg::OP_SAMPLE;
            item.word = sample_word(mode);
         end
         pending_words.push_back(item);
      end
   endtask

   task automatic wait_idle();
      while (pending_words.size() != 0 || req_ch.valid || expected_angles.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_offset(input logic [eaa_pkg::CODE_W-1:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      offset_now = value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // request driver
   always @(posedge clock) begin
      req_word_type nxt;
      if (reset) begin
         req_ch.valid <= 1'b0;
         burst_left = 0;
         gap_left = 0;
      end else begin
         if (req_ch.valid && req_ch.ready) track_word(req_ch.opcode, req_ch.raw_word);
         if (!req_ch.valid || req_ch.ready) begin
            if (gap_left > 0 || pending_words.size() == 0) begin
               if (gap_left > 0) gap_left--;
               req_ch.valid <= 1'b0;
            end else begin
               nxt = pending_words.pop_front();
               req_ch.valid <= 1'b1;
               req_ch.opcode <= nxt.op;
               req_ch.raw_word <= nxt.word;
               if (burst_left > 0) burst_left--;
               if (burst_left == 0) begin
                  if ($urandom_range(0, 7) == 0) begin
                     burst_left = $urandom_range(50, 200);
                     gap_left = 0;
                  end else begin
                     burst_left = $urandom_range(1, 12);
                     gap_left = ($urandom_range(0, 3) == 0) ? $urandom_range(6, 30)
                                                            : $urandom_range(0, 5);
                  end
               end
            end
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      angle_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         stall_pattern = 16'hFFFF;
         pattern_age = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_angles.size() == 0) begin
               error_count++;
               $display("%0t unexpected angle: code %0d fine %0d", $time,
                        rsp_ch.angle_code, rsp_ch.angle_fine);
            end else begin
               want = expected_angles.pop_front();
               if (rsp_ch.angle_code !== want.code) begin
                  error_count++;
                  $display("%0t angle_code mismatch: expected %0d, actual %0d", $time,
                           want.code, rsp_ch.angle_code);
               end
               if (rsp_ch.angle_fine !== want.fine) begin
                  error_count++;
                  $display("%0t angle_fine mismatch: expected %0d, actual %0d", $time,
                           want.fine, rsp_ch.angle_fine);
               end
            end
         end
         if (pattern_age == 0) begin
            pattern_age = $urandom_range(20, 120);
            stall_pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom) | 16'h1);
         end else begin
            pattern_age--;
         end
         rsp_ch.ready <= stall_pattern[0];
         stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb NOT OK");
         $finish;
      end
   end

   initial begin
      reset <= 1'b1;
      csr_wr_en <= 1'b0;
      csr_wr_data <= '0;
      for (int k = 0; k < 8; k++) ring_codes[k] = '0;
      ring_slot = '0;
      offset_now = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: early tick, rejected codes, stray bits, ring extremes
      @(negedge clock);
      pending_words.push_back('{eaa_pkg::OP_TICK, 16'hFFFF});
      pending_words.push_back('{eaa_pkg::OP_SAMPLE, 16'h0000});
      pending_words.push_back('{eaa_pkg::OP_SAMPLE, 16'hFFFF});
      pending_words.push_back('{eaa_pkg::OP_SAMPLE, 16'h0001});
      pending_words.push_back('{eaa_pkg::OP_SAMPLE, 16'hE000});
      pending_words.push_back('{eaa_pkg::OP_TICK, 16'h0000});
      pending_words.push_back('{eaa_pkg::OP_SAMPLE, 16'h0002});
      pending_words.push_back('{eaa_pkg::OP_TICK, 16'hAAAA});
      for (int k = 0; k < 8; k++) pending_words.push_back('{eaa_pkg::OP_SAMPLE, 16'h1FFD});
      pending_words.push_back('{eaa_pkg::OP_TICK, 16'h5555});
      pending_words.push_back('{eaa_pkg::OP_SAMPLE, 16'hE003});
      pending_words.push_back('{eaa_pkg::OP_TICK, 16'h8000});
      wait_idle();

      write_offset(12'hFFF);
      queue_random(300, FILL_ANY);
      wait_idle();

      write_offset(12'h000);
      queue_random(300, FILL_HIGH);
      wait_idle();

      write_offset(eaa_pkg::CODE_W'($urandom));
      queue_random(350, FILL_LOW);
      wait_idle();

      write_offset(12'h001);
      queue_random(400, FILL_ANY);
      wait_idle();

      write_offset(eaa_pkg::CODE_W'($urandom));
      queue_random(600, FILL_ANY);
      wait_idle();

      if (expected_angles.size() != 0) begin
         error_count++;
         $display("%0t %0d expected angles never arrived", $time, expected_angles.size());
      end
      if (error_count == 0)
         $display("tb OK");
      else
         $display("tb NOT OK");
      $finish;
   end

endmodule

[files.f]
hdl/eaa_pkg.sv
hdl/eaa_req_if.sv
hdl/eaa_rsp_if.sv
hdl/eaa_ram.sv
hdl/eaa_alu.sv
hdl/encoder_angle_averager_top.sv
hdl/eaa_checker.sv
sim/tb.sv
